// ===== design/rhp_pkg.sv =====
// Package with the types and constants of the RTP header parser and loss counter.
`default_nettype none
package rhp_pkg;

    // Default largest datagram, in bytes.
    localparam int unsigned MAX_DATAGRAM_DEF = 2048;

    // Fixed header length, the width of the header end pointer and of the payload count.
    localparam int unsigned FIXED_HEADER = 12;
    localparam int unsigned HEND_W       = 19;
    localparam int unsigned COUNT_W      = 12;

    // Byte offsets of the fixed header fields.
    localparam int unsigned HDR_POS_FLAGS  = 0;
    localparam int unsigned HDR_POS_TYPE   = 1;
    localparam int unsigned HDR_POS_SEQ_HI = 2;
    localparam int unsigned HDR_POS_SEQ_LO = 3;
    localparam int unsigned HDR_POS_TS_3   = 4;
    localparam int unsigned HDR_POS_TS_2   = 5;
    localparam int unsigned HDR_POS_TS_1   = 6;
    localparam int unsigned HDR_POS_TS_0   = 7;

    // Offsets into the extension header of its length word.
    localparam int unsigned EXT_LEN_HI_OFS = 2;
    localparam int unsigned EXT_LEN_LO_OFS = 3;

    // Kind of a result item.
    typedef enum logic [1:0] {
        ITEM_HEADER    = 2'd0,
        ITEM_PAYLOAD   = 2'd1,
        ITEM_MALFORMED = 2'd2
    } t_item_kind;

    // One result item.
    typedef struct packed {
        t_item_kind  item_kind;
        logic [6:0]  payload_type;
        logic [15:0] sequence_number;
        logic [31:0] media_timestamp;
        logic [7:0]  payload_value;
        logic [11:0] payload_count;
        logic [63:0] lost_packets;
        logic        final_item;
    } t_result;

endpackage
`default_nettype wire

// ===== design/rhp_in_if.sv =====
// Input channel of the RTP header parser: one datagram byte per item.
`default_nettype none
interface rhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source (output valid, data_byte, end_of_datagram, input ready);
    modport sink   (input valid, data_byte, end_of_datagram, output ready);
endinterface
`default_nettype wire

// ===== design/rhp_out_if.sv =====
// Output channel of the RTP header parser: header, payload and malformed items.
`default_nettype none
interface rhp_out_if;
    logic                valid;
    logic                ready;
    rhp_pkg::t_item_kind item_kind;
    logic [6:0]          payload_type;
    logic [15:0]         sequence_number;
    logic [31:0]         media_timestamp;
    logic [7:0]          payload_value;
    logic [11:0]         payload_count;
    logic [63:0]         lost_packets;
    logic                final_item;

    modport source (output valid, item_kind, payload_type, sequence_number,
                    media_timestamp, payload_value, payload_count, lost_packets,
                    final_item, input ready);
    modport sink   (input valid, item_kind, payload_type, sequence_number,
                    media_timestamp, payload_value, payload_count, lost_packets,
                    final_item, output ready);
endinterface
`default_nettype wire

// ===== design/rtp_header_parser_loss_counter.sv =====
// Top level of the RTP header parser with the running packet-loss counter.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------------
//  i_in    | in  | valid/ready   | data_byte, end_of_datagram
//  o_out   | out | valid/ready   | item_kind, payload_type, sequence_number,
//          |     |               | media_timestamp, payload_value, payload_count,
//          |     |               | lost_packets, final_item
//
// One byte is taken in every ready cycle; its result item, if any, enters the
// output queue on the next cycle. The rate is set by the single pass of position
// compare, field capture and the 64-bit saturating add of the loss count.
// A two-entry output queue (output register plus skid register) lets a byte be
// taken while a result waits; input ready drops only when both entries are full.
// Synchronous reset clears the parser state, the loss count and the queue.
`default_nettype none
module rtp_header_parser_loss_counter #(
    parameter int unsigned MAX_DATAGRAM = rhp_pkg::MAX_DATAGRAM_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rhp_in_if.sink    i_in,
    rhp_out_if.source o_out
);
    import rhp_pkg::*;

    // Position counts up to MAX_DATAGRAM; compares are done on a common width.
    localparam int unsigned POS_W = $clog2(MAX_DATAGRAM + 1);
    localparam int unsigned CMP_W = HEND_W + 1;
    localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_DATAGRAM);
    localparam logic [CMP_W-1:0] FIXED_CMP = CMP_W'(FIXED_HEADER);

    // Parser state.
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [HEND_W-1:0] r_hend, n_hend;
    logic              r_ext, n_ext;
    logic [7:0]        r_ext_hi, n_ext_hi;
    logic [6:0]        r_type, n_type;
    logic [15:0]       r_seq, n_seq;
    logic [31:0]       r_ts, n_ts;
    logic [15:0]       r_prev, n_prev;
    logic              r_have_prev, n_have_prev;
    logic [63:0]       r_loss, n_loss;

    // Output queue.
    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    t_result r_skid, n_skid;
    logic    r_skid_valid, n_skid_valid;

    logic    in_fire;
    logic    out_pop;
    logic    res_valid;
    t_result res;

    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  hend_c;
    logic              hdr_done;
    logic              last;
    logic [7:0]        b;
    logic [CMP_W-1:0]  count_c;
    logic [15:0]       loss_add;
    logic [64:0]       loss_sum;
    logic [HEND_W-1:0] ext_bytes;

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_pop    = r_out_valid && o_out.ready;

    assign b        = i_in.data_byte;
    assign last     = i_in.end_of_datagram;
    assign pos_c    = CMP_W'(r_pos);
    assign hend_c   = CMP_W'(r_hend);
    assign hdr_done = !r_ext && (pos_c >= hend_c);
    assign count_c  = pos_c - hend_c + CMP_W'(1);

    // Wrapped sequence gap minus one, added with saturation.
    assign loss_add = r_seq - r_prev - 16'd1;
    assign loss_sum = {1'b0, r_loss} + 65'(loss_add);

    // Extension length in bytes: four per word plus the extension's own word.
    assign ext_bytes = HEND_W'({({8'd0, r_ext_hi, b} + 24'd1), 2'b00});

    // Per-byte parsing and result generation.
    always_comb begin
        n_pos       = r_pos;
        n_hend      = r_hend;
        n_ext       = r_ext;
        n_ext_hi    = r_ext_hi;
        n_type      = r_type;
        n_seq       = r_seq;
        n_ts        = r_ts;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_loss      = r_loss;
        res_valid   = 1'b0;
        res         = '0;
        res.lost_packets = r_loss;

        if (in_fire) begin
            if (pos_c >= MAX_CMP) begin
                // Oversize datagram: bytes are dropped until the end mark.
                if (last) begin
                    if (!hdr_done) begin
                        res_valid      = 1'b1;
                        res.item_kind  = ITEM_MALFORMED;
                        res.final_item = 1'b1;
                    end
                    n_pos    = '0;
                    n_hend   = HEND_W'(FIXED_HEADER);
                    n_ext    = 1'b0;
                    n_ext_hi = '0;
                end
            end else begin
                if (hdr_done) begin
                    // Payload byte.
                    res_valid           = 1'b1;
                    res.item_kind       = ITEM_PAYLOAD;
                    res.payload_type    = r_type;
                    res.sequence_number = r_seq;
                    res.media_timestamp = r_ts;
                    res.payload_value   = b;
                    res.payload_count   = count_c[COUNT_W-1:0];
                    res.final_item      = last;
                end else begin
                    // Capture of the fixed header fields.
                    case (pos_c)
                        CMP_W'(HDR_POS_FLAGS): begin
                            n_hend = HEND_W'(FIXED_HEADER) + HEND_W'({b[3:0], 2'b00});
                            n_ext  = b[4];
                        end
                        CMP_W'(HDR_POS_TYPE):   n_type       = b[6:0];
                        CMP_W'(HDR_POS_SEQ_HI): n_seq[15:8]  = b;
                        CMP_W'(HDR_POS_SEQ_LO): n_seq[7:0]   = b;
                        CMP_W'(HDR_POS_TS_3):   n_ts[31:24]  = b;
                        CMP_W'(HDR_POS_TS_2):   n_ts[23:16]  = b;
                        CMP_W'(HDR_POS_TS_1):   n_ts[15:8]   = b;
                        CMP_W'(HDR_POS_TS_0):   n_ts[7:0]    = b;
                        default: ;
                    endcase

                    // Extension length word; its low byte closes the extension.
                    if (r_ext && pos_c >= FIXED_CMP) begin
                        if (pos_c == hend_c + CMP_W'(EXT_LEN_HI_OFS)) begin
                            n_ext_hi = b;
                        end else if (pos_c == hend_c + CMP_W'(EXT_LEN_LO_OFS)) begin
                            n_hend = r_hend + ext_bytes;
                            n_ext  = 1'b0;
                        end
                    end

                    // Header complete, or datagram cut short inside it.
                    if (!n_ext && (pos_c + CMP_W'(1) == CMP_W'(n_hend))) begin
                        if (r_have_prev) begin
                            n_loss = loss_sum[64] ? '1 : loss_sum[63:0];
                        end
                        n_prev              = r_seq;
                        n_have_prev         = 1'b1;
                        res_valid           = 1'b1;
                        res.item_kind       = ITEM_HEADER;
                        res.payload_type    = r_type;
                        res.sequence_number = r_seq;
                        res.media_timestamp = r_ts;
                        res.lost_packets    = n_loss;
                        res.final_item      = last;
                    end else if (last) begin
                        res_valid      = 1'b1;
                        res.item_kind  = ITEM_MALFORMED;
                        res.final_item = 1'b1;
                    end
                end

                if (last) begin
                    n_pos    = '0;
                    n_hend   = HEND_W'(FIXED_HEADER);
                    n_ext    = 1'b0;
                    n_ext_hi = '0;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
    end

    // Two-entry output queue.
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (out_pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = res;
                n_skid_valid = res_valid;
            end else begin
                n_out       = res;
                n_out_valid = res_valid;
            end
        end else if (!r_out_valid) begin
            n_out       = res;
            n_out_valid = res_valid;
        end else if (res_valid) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_hend       <= HEND_W'(FIXED_HEADER);
            r_ext        <= 1'b0;
            r_ext_hi     <= '0;
            r_type       <= '0;
            r_seq        <= '0;
            r_ts         <= '0;
            r_prev       <= '0;
            r_have_prev  <= 1'b0;
            r_loss       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_hend       <= n_hend;
            r_ext        <= n_ext;
            r_ext_hi     <= n_ext_hi;
            r_type       <= n_type;
            r_seq        <= n_seq;
            r_ts         <= n_ts;
            r_prev       <= n_prev;
            r_have_prev  <= n_have_prev;
            r_loss       <= n_loss;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers of the output queue.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // Output channel.
    assign o_out.valid           = r_out_valid;
    assign o_out.item_kind       = r_out.item_kind;
    assign o_out.payload_type    = r_out.payload_type;
    assign o_out.sequence_number = r_out.sequence_number;
    assign o_out.media_timestamp = r_out.media_timestamp;
    assign o_out.payload_value   = r_out.payload_value;
    assign o_out.payload_count   = r_out.payload_count;
    assign o_out.lost_packets    = r_out.lost_packets;
    assign o_out.final_item      = r_out.final_item;

`ifndef NO_ASSERTIONS
    // The skid entry is only filled behind a waiting output entry.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output entry is empty");

    // The loss count never goes down outside reset.
    a_loss_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_loss >= $past(r_loss)))
        else $error("loss count decreased");

    // A malformed item always closes its datagram.
    a_malformed_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.item_kind == ITEM_MALFORMED) |-> r_out.final_item)
        else $error("malformed item without final mark");

    // The byte position never passes the datagram limit.
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (pos_c <= MAX_CMP))
        else $error("byte position beyond datagram limit");
`endif

endmodule
`default_nettype wire
